>>> rtl/nlu_pkg.sv
`timescale 1ns / 1ps

package nlu_pkg;

    // Shared multiplier geometry: signed A x signed B, product rounded by 2^16.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 29;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int RND_W   = MUL_P_W - 16;
    localparam int SUM_W   = 48;

    // Q0.16 / Q16.16 gains
    localparam logic signed [MUL_B_W-1:0] K_P10  = 29'sd6554;
    localparam logic signed [MUL_B_W-1:0] K_P05  = 29'sd3277;
    localparam logic signed [MUL_B_W-1:0] K_P20  = 29'sd13107;
    localparam logic signed [MUL_B_W-1:0] K_P15  = 29'sd9830;
    localparam logic signed [MUL_B_W-1:0] K_P90  = 29'sd58982;
    localparam logic signed [MUL_B_W-1:0] K_P110 = 29'sd72090;
    localparam logic signed [RND_W-1:0]   K_ONE  = 47'sd65536;

    localparam logic [30:0] STEP_TIME_RESET = 31'd65536;

    // Configuration register indexes
    localparam logic [2:0] CFG_STEP_TIME  = 3'd0;
    localparam logic [2:0] CFG_DECAY      = 3'd1;
    localparam logic [2:0] CFG_BASE_DA    = 3'd2;
    localparam logic [2:0] CFG_BASE_5HT   = 3'd3;
    localparam logic [2:0] CFG_BASE_NE    = 3'd4;
    localparam logic [2:0] CFG_BASE_ACH   = 3'd5;

    localparam logic REQ_STEP   = 1'b0;
    localparam logic REQ_REWARD = 1'b1;

    // Level slots
    localparam logic [1:0] LVL_DA  = 2'd0;
    localparam logic [1:0] LVL_5HT = 2'd1;
    localparam logic [1:0] LVL_NE  = 2'd2;
    localparam logic [1:0] LVL_ACH = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [30:0]        time_since_spike;
        logic               inhibitory;
        logic signed [31:0] adaptation_in;
        logic signed [31:0] reward_value;
    } nlu_req_t;

    typedef struct packed {
        logic signed [31:0] adaptation_out;
        logic signed [31:0] dopamine_level;
        logic signed [31:0] serotonin_level;
        logic signed [31:0] noradrenaline_level;
        logic signed [31:0] acetylcholine_level;
    } nlu_rsp_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] value;
    } nlu_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DONE
    } nlu_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DECAY,
        OP_DA_GAIN,
        OP_ADAPT_K,
        OP_RPE,
        OP_RPE_ABS,
        OP_ADAPT_RWD
    } nlu_op_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_DECAY,
        WB_K,
        WB_ADAPT_STEP,
        WB_RPE,
        WB_NE,
        WB_ADAPT_RWD
    } nlu_wb_t;

    typedef struct packed {
        nlu_op_t    op;
        logic [1:0] op_lvl;
        nlu_wb_t    wb;
        logic [1:0] wb_lvl;
        logic       last;
    } nlu_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > SUM_W'(64'sh7FFF_FFFF))
            r = 32'sh7FFF_FFFF;
        else if (v < -SUM_W'(64'sh8000_0000))
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> rtl/nlu_stream_if.sv
`timescale 1ns / 1ps

interface nlu_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/neuromodulator_level_update.sv
`timescale 1ns / 1ps

// Neuromodulator level update.
// req carries one beat per neuron item: a time step (spike test, spike
// increments, decay of all four levels toward baseline, adaptation scaled by
// dopamine) or a reward event (prediction-error update, adaptation x0.9/1.1).
// rsp returns one beat per item: adaptation_out and the four levels after it.
// cfg writes the six registers by index; it is always ready, writes to
// indexes above five are dropped. Write it only while the block is idle.
// All products go through one shared registered 34x29 multiplier, stepped
// by a small sequencer; req is ready only in idle.
// Time step: prep, 8 multiply and write-back steps and an output load,
// then idle again. Reward: prep, its multiply and write-back steps, output load.
// A new item is taken only after the last one has passed its output load.
// The finished result sits in an output register; if rsp stalls the next
// item still runs and waits only at its output load.
// Reset clears levels to zero, step_time to 1.0 ms, factors and baselines
// to zero, and empties the output register.
module neuromodulator_level_update (
    input  logic         clk,
    input  logic         rst_n,
    nlu_stream_if.sink   req,
    nlu_stream_if.source rsp,
    nlu_stream_if.sink   cfg
);
    import nlu_pkg::*;

    nlu_state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;

    logic [30:0]        step_time_reg;
    logic [63:0]        decay_reg;
    logic signed [31:0] base_reg [4];
    logic signed [31:0] lvl_reg  [4];
    logic signed [31:0] lvl_next [4];

    nlu_req_t           item_reg;
    logic signed [33:0] e_reg, e_next;
    logic signed [28:0] k_reg;
    logic signed [31:0] adapt_reg;
    nlu_rsp_t           out_reg;
    logic               out_valid_reg, out_valid_next;

    nlu_ctrl_t          ctrl;
    logic               accept;
    logic               out_load;
    logic               spike;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [RND_W-1:0]   rnd;
    logic signed [SUM_W-1:0]   rnd_ext;
    logic signed [RND_W-1:0]   k_wide;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    assign spike   = item_reg.time_since_spike < step_time_reg;
    assign rnd_ext = SUM_W'(rnd);
    assign k_wide  = K_ONE - rnd;

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_RUN;
                step_next  = 3'd0;
            end
            ST_RUN:
            begin
                step_next = step_reg + 3'd1;
                if (ctrl.last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: operation issued this cycle, write-back of last one
    always_comb
    begin
        ctrl.op     = OP_NONE;
        ctrl.op_lvl = 2'd0;
        ctrl.wb     = WB_NONE;
        ctrl.wb_lvl = 2'd0;
        ctrl.last   = 1'b0;
        if (state_reg == ST_RUN)
        begin
            if (item_reg.req_type == REQ_STEP)
            begin
                unique case (step_reg)
                    3'd0, 3'd1, 3'd2, 3'd3:
                    begin
                        ctrl.op     = OP_DECAY;
                        ctrl.op_lvl = step_reg[1:0];
                        if (step_reg != 3'd0)
                        begin
                            ctrl.wb     = WB_DECAY;
                            ctrl.wb_lvl = step_reg[1:0] - 2'd1;
                        end
                    end
                    3'd4:
                    begin
                        ctrl.op     = OP_DA_GAIN;
                        ctrl.wb     = WB_DECAY;
                        ctrl.wb_lvl = LVL_ACH;
                    end
                    3'd5:
                    begin
                        ctrl.wb = WB_K;
                    end
                    3'd6:
                    begin
                        ctrl.op = OP_ADAPT_K;
                    end
                    3'd7:
                    begin
                        ctrl.wb   = WB_ADAPT_STEP;
                        ctrl.last = 1'b1;
                    end
                    default:
                    begin
                        ctrl.last = 1'b1;
                    end
                endcase
            end
            else
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        ctrl.op = OP_RPE;
                    end
                    3'd1:
                    begin
                        ctrl.op = OP_RPE_ABS;
                        ctrl.wb = WB_RPE;
                    end
                    3'd2:
                    begin
                        ctrl.op = OP_ADAPT_RWD;
                        ctrl.wb = WB_NE;
                    end
                    default:
                    begin
                        ctrl.wb   = WB_ADAPT_RWD;
                        ctrl.last = 1'b1;
                    end
                endcase
            end
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.op)
            OP_DECAY:
            begin
                mul_a = MUL_A_W'(lvl_reg[ctrl.op_lvl]) - MUL_A_W'(base_reg[ctrl.op_lvl]);
                mul_b = MUL_B_W'(decay_reg[{ctrl.op_lvl, 4'b0000} +: 16]);
            end
            OP_DA_GAIN:
            begin
                mul_a = MUL_A_W'(lvl_reg[LVL_DA]);
                mul_b = K_P10;
            end
            OP_ADAPT_K:
            begin
                mul_a = MUL_A_W'(item_reg.adaptation_in);
                mul_b = k_reg;
            end
            OP_RPE:
            begin
                mul_a = e_reg;
                mul_b = K_P10;
            end
            OP_RPE_ABS:
            begin
                mul_a = e_reg[33] ? -e_reg : e_reg;
                mul_b = K_P20;
            end
            OP_ADAPT_RWD:
            begin
                mul_a = MUL_A_W'(item_reg.adaptation_in);
                mul_b = (e_reg > 34'sd0) ? K_P90 : K_P110;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    nlu_mul_unit u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .rnd (rnd)
    );

    // level updates: spike increments and prediction error in prep, write-backs in run
    always_comb
    begin
        lvl_next = lvl_reg;
        e_next   = e_reg;
        if (state_reg == ST_PREP)
        begin
            if (item_reg.req_type == REQ_STEP)
            begin
                if (spike)
                begin
                    lvl_next[LVL_DA] = sat32(SUM_W'(lvl_reg[LVL_DA]) + SUM_W'(K_P10));
                    lvl_next[LVL_NE] = sat32(SUM_W'(lvl_reg[LVL_NE]) + SUM_W'(K_P20));
                    if (item_reg.inhibitory)
                        lvl_next[LVL_5HT] = sat32(SUM_W'(lvl_reg[LVL_5HT]) + SUM_W'(K_P05));
                    else
                        lvl_next[LVL_ACH] = sat32(SUM_W'(lvl_reg[LVL_ACH]) + SUM_W'(K_P15));
                end
            end
            else
            begin
                e_next = 34'(item_reg.reward_value) - 34'(lvl_reg[LVL_DA]);
            end
        end
        case (ctrl.wb)
            WB_DECAY:
            begin
                lvl_next[ctrl.wb_lvl] = sat32(SUM_W'(base_reg[ctrl.wb_lvl]) + rnd_ext);
            end
            WB_RPE:
            begin
                lvl_next[LVL_DA]  = sat32(SUM_W'(lvl_reg[LVL_DA]) + rnd_ext);
                lvl_next[LVL_5HT] = sat32(SUM_W'(lvl_reg[LVL_5HT]) + rnd_ext);
            end
            WB_NE:
            begin
                lvl_next[LVL_NE] = sat32(SUM_W'(lvl_reg[LVL_NE]) + rnd_ext);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
            step_time_reg <= STEP_TIME_RESET;
            decay_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                base_reg[i] <= '0;
                lvl_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            lvl_reg       <= lvl_next;
            if (cfg.valid)
            begin
                unique case (cfg.data.index)
                    CFG_STEP_TIME: step_time_reg <= cfg.data.value[30:0];
                    CFG_DECAY:     decay_reg     <= cfg.data.value;
                    CFG_BASE_DA:   base_reg[LVL_DA]  <= cfg.data.value[31:0];
                    CFG_BASE_5HT:  base_reg[LVL_5HT] <= cfg.data.value[31:0];
                    CFG_BASE_NE:   base_reg[LVL_NE]  <= cfg.data.value[31:0];
                    CFG_BASE_ACH:  base_reg[LVL_ACH] <= cfg.data.value[31:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req.data;
        e_reg <= e_next;
        case (ctrl.wb)
            WB_K:
            begin
                k_reg <= k_wide[28:0];
            end
            WB_ADAPT_STEP:
            begin
                // clamp at zero, saturate high
                if (rnd < RND_W'(0))
                    adapt_reg <= '0;
                else
                    adapt_reg <= sat32(rnd_ext);
            end
            WB_ADAPT_RWD:
            begin
                adapt_reg <= sat32(rnd_ext);
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_reg.adaptation_out      <= adapt_reg;
            out_reg.dopamine_level      <= lvl_reg[LVL_DA];
            out_reg.serotonin_level     <= lvl_reg[LVL_5HT];
            out_reg.noradrenaline_level <= lvl_reg[LVL_NE];
            out_reg.acetylcholine_level <= lvl_reg[LVL_ACH];
        end
    end

endmodule

>>> rtl/nlu_mul_unit.sv
`timescale 1ns / 1ps

module nlu_mul_unit (
    input  logic                                 clk,
    input  logic signed [nlu_pkg::MUL_A_W-1:0]   a,
    input  logic signed [nlu_pkg::MUL_B_W-1:0]   b,
    output logic signed [nlu_pkg::RND_W-1:0]     rnd
);
    import nlu_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;
    logic signed [MUL_P_W-1:0] biased;

    assign prod_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // round half up: floor((p + 2^15) / 2^16)
    assign biased = prod_reg + MUL_P_W'(32768);
    assign rnd    = biased[MUL_P_W-1:16];

endmodule

>>> tb/nlu_level_checker.sv
`timescale 1ns / 1ps

module nlu_level_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  nlu_pkg::nlu_req_t req_data,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  nlu_pkg::nlu_rsp_t rsp_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  nlu_pkg::nlu_cfg_t cfg_data,
    output int                reports_owed,
    output int                mismatches
);
    import nlu_pkg::*;

    localparam longint Q_MAX        = 64'sd2147483647;
    localparam longint Q_MIN        = -64'sd2147483648;

    // Shadow of the configuration registers
    logic [30:0]        step_len;
    logic [63:0]        decay_f;
    logic signed [31:0] base_da, base_5ht, base_ne, base_ach;

    // Shadow of the four levels
    logic signed [31:0] lvl_da, lvl_5ht, lvl_ne, lvl_ach;

    nlu_rsp_t level_reports[$];

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > Q_MAX)
            return 32'sh7FFF_FFFF;
        if (v < Q_MIN)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Drop 16 fraction bits, round to nearest, ties up
    function automatic longint round_q16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] relax(input logic signed [31:0] lvl,
                                                 input logic signed [31:0] base,
                                                 input logic [15:0] f);
        longint diff;
        diff = longint'(lvl) - longint'(base);
        return clip32(longint'(base) + round_q16(diff * longint'(f)));
    endfunction

    task automatic update_levels(input nlu_req_t r, output nlu_rsp_t res);
        longint a, e, mag, gain, k, v;
        a = longint'(r.adaptation_in);
        if (r.req_type == REQ_STEP)
        begin
            if (r.time_since_spike < step_len)
            begin
                lvl_da = clip32(longint'(lvl_da) + longint'(K_P10));
                if (r.inhibitory)
                    lvl_5ht = clip32(longint'(lvl_5ht) + longint'(K_P05));
                lvl_ne = clip32(longint'(lvl_ne) + longint'(K_P20));
                if (!r.inhibitory)
                    lvl_ach = clip32(longint'(lvl_ach) + longint'(K_P15));
            end
            lvl_da  = relax(lvl_da,  base_da,  decay_f[15:0]);
            lvl_5ht = relax(lvl_5ht, base_5ht, decay_f[31:16]);
            lvl_ne  = relax(lvl_ne,  base_ne,  decay_f[47:32]);
            lvl_ach = relax(lvl_ach, base_ach, decay_f[63:48]);
            // gain uses the decayed dopamine
            k = longint'(K_ONE) - round_q16(longint'(lvl_da) * longint'(K_P10));
            v = round_q16(a * k);
            if (v < 0)
                v = 0;
            res.adaptation_out = clip32(v);
        end
        else
        begin
            // prediction error against the old dopamine
            e    = longint'(r.reward_value) - longint'(lvl_da);
            mag  = (e < 0) ? -e : e;
            gain = round_q16(e * longint'(K_P10));
            lvl_da  = clip32(longint'(lvl_da) + gain);
            lvl_5ht = clip32(longint'(lvl_5ht) + gain);
            lvl_ne  = clip32(longint'(lvl_ne) + round_q16(mag * longint'(K_P20)));
            res.adaptation_out = clip32(round_q16(a * ((e > 0) ? longint'(K_P90)
                                                               : longint'(K_P110))));
        end
        res.dopamine_level      = lvl_da;
        res.serotonin_level     = lvl_5ht;
        res.noradrenaline_level = lvl_ne;
        res.acetylcholine_level = lvl_ach;
    endtask

    task automatic check_level(input string what, input logic [31:0] want,
                               input logic [31:0] got, inout bit bad);
        if (want !== got)
        begin
            bad = 1'b1;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        nlu_rsp_t want;
        bit       bad;
        if (!rst_n)
        begin
            step_len      = STEP_TIME_RESET;
            decay_f       = '0;
            base_da       = '0;
            base_5ht      = '0;
            base_ne       = '0;
            base_ach      = '0;
            lvl_da        = '0;
            lvl_5ht       = '0;
            lvl_ne        = '0;
            lvl_ach       = '0;
            mismatches    = 0;
            reports_owed  = 0;
            level_reports.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.index)
                    CFG_STEP_TIME: step_len = cfg_data.value[30:0];
                    CFG_DECAY:     decay_f  = cfg_data.value;
                    CFG_BASE_DA:   base_da  = cfg_data.value[31:0];
                    CFG_BASE_5HT:  base_5ht = cfg_data.value[31:0];
                    CFG_BASE_NE:   base_ne  = cfg_data.value[31:0];
                    CFG_BASE_ACH:  base_ach = cfg_data.value[31:0];
                    default: ;
                endcase
            end
            // result side first: a beat accepted now can't belong to a request
            // accepted on the same edge
            if (rsp_valid && rsp_ready)
            begin
                if (level_reports.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, rsp_data);
                    mismatches++;
                end
                else
                begin
                    want = level_reports.pop_front();
                    bad  = 1'b0;
                    check_level("adaptation_out", want.adaptation_out,
                                rsp_data.adaptation_out, bad);
                    check_level("dopamine_level", want.dopamine_level,
                                rsp_data.dopamine_level, bad);
                    check_level("serotonin_level", want.serotonin_level,
                                rsp_data.serotonin_level, bad);
                    check_level("noradrenaline_level", want.noradrenaline_level,
                                rsp_data.noradrenaline_level, bad);
                    check_level("acetylcholine_level", want.acetylcholine_level,
                                rsp_data.acetylcholine_level, bad);
                    if (bad)
                        mismatches++;
                end
            end
            if (req_valid && req_ready)
            begin
                update_levels(req_data, want);
                level_reports.push_back(want);
            end
            reports_owed = level_reports.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nlu_pkg::*;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          PHASES         = 12;
    localparam int          ITEMS_PER_PHASE = 50;
    // indexes past the register file; writes there must be dropped
    localparam logic [2:0]  CFG_SPARE_A    = 3'd6;
    localparam logic [2:0]  CFG_SPARE_B    = 3'd7;
    localparam logic [31:0] W_MAX          = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN          = 32'h8000_0000;
    localparam logic [30:0] TSS_MAX        = 31'h7FFF_FFFF;

    logic clk;
    logic rst_n;
    logic req_fire = 1'b0;
    logic cfg_fire = 1'b0;

    int          reports_owed;
    int          mismatches;
    int          cycle_count;
    int          burst_left;
    logic [30:0] cur_step;

    nlu_stream_if #(.T(nlu_req_t)) req_ch ();
    nlu_stream_if #(.T(nlu_rsp_t)) rsp_ch ();
    nlu_stream_if #(.T(nlu_cfg_t)) cfg_ch ();

    neuromodulator_level_update DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    nlu_level_checker level_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_ch.valid),
        .req_ready    (req_ch.ready),
        .req_data     (req_ch.data),
        .rsp_valid    (rsp_ch.valid),
        .rsp_ready    (rsp_ch.ready),
        .rsp_data     (rsp_ch.data),
        .cfg_valid    (cfg_ch.valid),
        .cfg_ready    (cfg_ch.ready),
        .cfg_data     (cfg_ch.data),
        .reports_owed (reports_owed),
        .mismatches   (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // handshake flags, read back at the falling edge
    always @(posedge clk)
    begin
        req_fire <= req_ch.valid && req_ch.ready;
        cfg_fire <= cfg_ch.valid && cfg_ch.ready;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** neuromodulator_level_update: FAILED **");
        $finish;
    end

    // result side: stretches of free flow, random stalls and periodic stalls
    initial
    begin
        int mode;
        int len;
        rsp_ch.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(16, 96);
            for (int n = 0; n < len; n++)
            begin
                @(negedge clk);
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= (n % 7 == 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return 32'd0;
            3, 4:    return $urandom;
            default: return 32'($urandom_range(0, 1048576)) - 32'd524288;
        endcase
    endfunction

    function automatic nlu_req_t mk_req(input logic kind, input logic [30:0] tss,
                                        input logic inh, input logic [31:0] a,
                                        input logic [31:0] r);
        nlu_req_t item;
        item.req_type         = kind;
        item.time_since_spike = tss;
        item.inhibitory       = inh;
        item.adaptation_in    = a;
        item.reward_value     = r;
        return item;
    endfunction

    function automatic nlu_req_t random_req();
        nlu_req_t item;
        item.req_type = ($urandom_range(0, 99) < 40) ? REQ_REWARD : REQ_STEP;
        case ($urandom_range(0, 7))
            0:       item.time_since_spike = '0;
            1:       item.time_since_spike = TSS_MAX;
            2:       item.time_since_spike = cur_step - 31'd1;
            3:       item.time_since_spike = cur_step;
            4:       item.time_since_spike = cur_step + 31'd1;
            default: item.time_since_spike = 31'($urandom);
        endcase
        item.inhibitory    = 1'($urandom);
        item.adaptation_in = pick_word();
        item.reward_value  = pick_word();
        return item;
    endfunction

    // called at a falling edge; returns at the falling edge after the accept
    task automatic drive_req(input nlu_req_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(negedge clk);
        while (!req_fire)
            @(negedge clk);
    endtask

    task automatic cfg_put(input logic [2:0] idx, input logic [63:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        @(negedge clk);
        while (!cfg_fire)
            @(negedge clk);
    endtask

    task automatic write_config(input logic [30:0] st, input logic [63:0] f,
                                input logic [31:0] b_da, input logic [31:0] b_5ht,
                                input logic [31:0] b_ne, input logic [31:0] b_ach);
        cur_step = st;
        cfg_put(CFG_STEP_TIME, {33'd0, st});
        cfg_put(CFG_DECAY, f);
        cfg_put(CFG_BASE_DA, {32'd0, b_da});
        cfg_put(CFG_BASE_5HT, {32'd0, b_5ht});
        cfg_put(CFG_BASE_NE, {32'd0, b_ne});
        cfg_put(CFG_BASE_ACH, {32'd0, b_ach});
        // after the real ones, so an aliased decode would clobber a register
        cfg_put(CFG_SPARE_A, {$urandom, $urandom});
        cfg_put(CFG_SPARE_B, {$urandom, $urandom});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [30:0] st;
        logic [63:0] f;
        case ($urandom_range(0, 4))
            0:       st = '0;
            1:       st = TSS_MAX;
            2:       st = STEP_TIME_RESET;
            default: st = 31'($urandom);
        endcase
        for (int n = 0; n < 4; n++)
        begin
            case ($urandom_range(0, 4))
                0:       f[16*n +: 16] = 16'h0000;
                1:       f[16*n +: 16] = 16'hFFFF;
                2, 3:    f[16*n +: 16] = 16'($urandom_range(16'hE000, 16'hFFFF));
                default: f[16*n +: 16] = 16'($urandom);
            endcase
        end
        write_config(st, f, pick_word(), pick_word(), pick_word(), pick_word());
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (reports_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        rst_n        = 1'b0;
        burst_left   = 0;
        cur_step     = STEP_TIME_RESET;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration: levels snap to zero baselines every step
        drive_req(mk_req(REQ_STEP, '0, 1'b0, W_MAX, 32'd0));
        drive_req(mk_req(REQ_STEP, '0, 1'b1, W_MIN, 32'd0));
        drive_req(mk_req(REQ_STEP, 31'd65535, 1'b0, 32'h0001_0000, 32'd0));
        drive_req(mk_req(REQ_STEP, 31'd65536, 1'b1, 32'hFFFF_FFFF, 32'd0));
        drive_req(mk_req(REQ_STEP, TSS_MAX, 1'b0, 32'd0, W_MAX));
        // zero prediction error takes the x1.1 branch
        drive_req(mk_req(REQ_REWARD, TSS_MAX, 1'b1, W_MAX, 32'd0));
        drive_req(mk_req(REQ_REWARD, '0, 1'b0, W_MAX, W_MAX));
        drive_req(mk_req(REQ_REWARD, '0, 1'b1, W_MIN, W_MIN));
        drive_req(mk_req(REQ_REWARD, 31'd12345, 1'b0, 32'hFFFF_0000, 32'd1));
        drive_req(mk_req(REQ_REWARD, TSS_MAX, 1'b1, 32'h0001_0000, 32'hFFFF_FFFF));
        wait_idle();

        // levels pinned at the top: adaptation gain goes negative
        write_config(TSS_MAX, 64'd0, W_MAX, W_MAX, W_MAX, W_MAX);
        drive_req(mk_req(REQ_STEP, '0, 1'b0, 32'h0001_0000, 32'd0));
        drive_req(mk_req(REQ_STEP, '0, 1'b1, W_MIN, 32'd0));
        drive_req(mk_req(REQ_REWARD, '0, 1'b0, W_MAX, W_MIN));
        wait_idle();

        // no spike possible, slow decay toward the bottom
        write_config('0, 64'hFFFF_FFFF_FFFF_FFFF, W_MIN, W_MIN, W_MIN, W_MIN);
        drive_req(mk_req(REQ_STEP, '0, 1'b1, W_MAX, 32'd0));
        drive_req(mk_req(REQ_REWARD, '0, 1'b0, W_MIN, W_MAX));
        drive_req(mk_req(REQ_STEP, '0, 1'b0, W_MIN, 32'd0));
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            random_config();
            repeat (ITEMS_PER_PHASE) drive_req(random_req());
            wait_idle();
        end

        if (mismatches == 0)
            $display("** neuromodulator_level_update: PASSED **");
        else
            $display("** neuromodulator_level_update: FAILED **");
        $finish;
    end

endmodule
